// File: rtl/core/lscap_pkg.sv
// ----------------------------------------------------------------------------
// lscap_pkg - shared types and constants of the lidar sector / cone unit
// Configuration record, register indexes, the classified sample passed from
// the front end to the back end, and the result record.
// ----------------------------------------------------------------------------
package lscap_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SCAN_LENGTH    = 3'd0,
    REG_WINDOW_START   = 3'd1,
    REG_WINDOW_END     = 3'd2,
    REG_CENTER_HALF    = 3'd3,
    REG_RANGE_MAX      = 3'd4,
    REG_OBSTACLE_THR   = 3'd5,
    REG_CONE_DETECT    = 3'd6,
    REG_APPROACH       = 3'd7
  } reg_index_t;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [12:0] RST_SCAN_LENGTH  = 13'd450;
  localparam logic [11:0] RST_WINDOW_START = 12'd0;
  localparam logic [11:0] RST_WINDOW_END   = 12'd449;
  localparam logic [11:0] RST_CENTER_HALF  = 12'd12;
  localparam logic [15:0] RST_RANGE_MAX    = 16'd12000;
  localparam logic [15:0] RST_OBSTACLE_THR = 16'd1000;
  localparam logic [15:0] RST_CONE_DETECT  = 16'd2000;

  // Sample filters
  localparam logic [15:0] SECTOR_MIN_VALID = 16'd50;

  // Drive command constants (rate in 1/1024 rad/s)
  localparam logic [15:0]        REACHED_MM   = 16'd300;
  localparam logic signed [10:0] SEARCH_RATE  = 11'sd512;
  localparam logic [10:0]        RATE_LIMIT   = 11'd512;
  localparam logic [10:0]        FAST_TURN    = 11'd154;
  localparam logic [15:0]        CLOSE_MM     = 16'd800;
  localparam logic [7:0]         SPEED_TURN   = 8'd100;
  localparam logic [7:0]         SPEED_CLOSE  = 8'd120;
  localparam logic [7:0]         SPEED_CRUISE = 8'd200;
  localparam logic [7:0]         SPEED_STOP   = 8'd0;
  localparam int                 DEAD_BAND    = 100;

  // Queue between front end and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [12:0] scan_length;
    logic [11:0] window_start;
    logic [11:0] window_end;
    logic [11:0] center_half_width;
    logic [15:0] range_max_mm;
    logic [15:0] obstacle_threshold_mm;
    logic [15:0] cone_detect_mm;
    logic        approach_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    SEC_NONE  = 2'd0,
    SEC_LEFT  = 2'd1,
    SEC_FRONT = 2'd2,
    SEC_RIGHT = 2'd3
  } sector_t;

  // One classified sample
  typedef struct packed {
    logic [15:0] range_mm;
    sector_t     sector;
    logic        cone_left;
    logic        cone_right;
    logic        cone_center;
    logic        first;
    logic        last;
  } op_t;

  typedef struct packed {
    logic [15:0]        left_min_mm;
    logic [15:0]        front_min_mm;
    logic [15:0]        right_min_mm;
    logic               obstacle_near;
    logic               drive_valid;
    logic [7:0]         linear_speed_mm_s;
    logic signed [10:0] angular_rate;
    logic               cone_reached;
  } result_t;

endpackage

// File: rtl/core/lscap_queue.sv
// ----------------------------------------------------------------------------
// lscap_queue - short queue of classified samples
// Decouples the front end from the back end so that each side stalls on its
// own while the back end works out a drive command.
// ----------------------------------------------------------------------------
module lscap_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  lscap_pkg::op_t  wr_data,
  output logic            q_full,
  input  logic            rd_en,
  output lscap_pkg::op_t  rd_data,
  output logic            q_empty
);
  import lscap_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !q_full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en && !q_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en && !q_full, rd_en && !q_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/lscap_front.sv
// ----------------------------------------------------------------------------
// lscap_front - sample intake and classification
// Registers each sample, counts its index in the scan, and tags it with the
// sector and cone windows it belongs to before queueing it.
// ----------------------------------------------------------------------------
module lscap_front #(
  parameter int MAX_SCAN = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  lscap_pkg::cfg_t cfg,
  input  logic            push,
  output logic            full,
  input  logic [15:0]     range_mm,
  input  logic            last_of_scan,
  input  logic            q_full,
  output logic            q_push,
  output lscap_pkg::op_t  q_data
);
  import lscap_pkg::*;

  localparam int CNT_W = $clog2(MAX_SCAN + 1);
  localparam int IW    = (CNT_W > 13) ? CNT_W : 13;
  localparam logic [12:0] LEN_CAP = 13'((MAX_SCAN > 8191) ? 8191 : MAX_SCAN);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SCAN);
  // len/3 as len*21846 >> 16, exact for len below 8192
  localparam logic [14:0] THIRD_MUL = 15'd21846;

  // Input stage
  logic        st_valid;
  logic [15:0] st_range;
  logic        st_last;

  // Scan position
  logic [CNT_W-1:0] count;

  // Window bounds derived from configuration
  logic [11:0]        third;
  logic signed [15:0] mid;
  logic signed [15:0] center_lo;
  logic signed [15:0] center_hi;

  logic [12:0]        len;
  logic [27:0]        third_prod;
  logic signed [13:0] span;
  logic signed [13:0] half;
  logic signed [13:0] mid_next;
  logic [IW-1:0]      idx_x;
  logic [IW-1:0]      len_x;
  logic [IW-1:0]      third_x;
  logic [IW-1:0]      two_third_x;
  logic signed [15:0] idx_s;
  logic signed [15:0] ws_s;
  logic signed [15:0] we_s;
  logic               in_len;
  logic               cone_ok;

  assign full   = st_valid && q_full;
  assign q_push = st_valid;

  // Precompute thirds and window middle in registers ahead of use
  always_comb begin
    len        = (cfg.scan_length < LEN_CAP) ? cfg.scan_length : LEN_CAP;
    third_prod = 28'(len) * 28'(THIRD_MUL);
    span       = $signed({2'b00, cfg.window_end}) - $signed({2'b00, cfg.window_start});
    half       = (span + $signed(14'(span < 0))) >>> 1;
    mid_next   = $signed({2'b00, cfg.window_start}) + half;
  end

  always_ff @(posedge clk) begin
    third     <= third_prod[27:16];
    mid       <= 16'(mid_next);
    center_lo <= 16'(mid_next) - $signed({4'b0000, cfg.center_half_width});
    center_hi <= 16'(mid_next) + $signed({4'b0000, cfg.center_half_width});
  end

  // Classify the staged sample
  always_comb begin
    idx_x       = IW'(count);
    len_x       = IW'(len);
    third_x     = IW'(third);
    two_third_x = IW'({third, 1'b0});
    idx_s       = $signed({3'b000, idx_x[12:0]});
    ws_s        = $signed({4'b0000, cfg.window_start});
    we_s        = $signed({4'b0000, cfg.window_end});
    in_len      = idx_x < len_x;
    cone_ok     = in_len && cfg.approach_enable && (st_range != '0);

    q_data.range_mm = st_range;
    q_data.first    = (count == '0);
    q_data.last     = st_last;
    if (!in_len || st_range <= SECTOR_MIN_VALID) begin
      q_data.sector = SEC_NONE;
    end else if (idx_x < third_x) begin
      q_data.sector = SEC_LEFT;
    end else if (idx_x < two_third_x) begin
      q_data.sector = SEC_FRONT;
    end else begin
      q_data.sector = SEC_RIGHT;
    end
    q_data.cone_left   = cone_ok && (idx_s >= ws_s) && (idx_s <= mid);
    q_data.cone_right  = cone_ok && (idx_s > mid) && (idx_s <= we_s);
    q_data.cone_center = cone_ok && (idx_s >= center_lo) && (idx_s <= center_hi);
  end

  // Hold the input stage while the queue is full
  always_ff @(posedge clk) begin
    if (push && !full) begin
      st_range <= range_mm;
      st_last  <= last_of_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      count    <= '0;
    end else begin
      if (push && !full) begin
        st_valid <= 1'b1;
      end else if (!q_full) begin
        st_valid <= 1'b0;
      end
      // Advance scan index as the sample enters the queue
      if (st_valid && !q_full) begin
        if (st_last) begin
          count <= '0;
        end else if (count != CNT_MAX) begin
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/lscap_back.sv
// ----------------------------------------------------------------------------
// lscap_back - running minima and drive command sequencer
// Folds each queued sample into the six minima; on the last sample of a scan
// it forms the report and, in approach mode, the smoothed steering command.
// ----------------------------------------------------------------------------
module lscap_back (
  input  logic               clk,
  input  logic               rst,
  input  lscap_pkg::cfg_t    cfg,
  input  lscap_pkg::op_t     op,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               res_ready,
  output logic               res_push,
  output lscap_pkg::result_t res
);
  import lscap_pkg::*;

  localparam int NUM_W = 31;
  localparam int REM_W = 30;
  localparam logic signed [NUM_W-1:0] GAIN_DIFF = 31'sd4608;
  localparam logic signed [NUM_W-1:0] GAIN_PREV = 31'sd70000;
  localparam logic [REM_W-1:0] CLAMP_ABS   = 30'd51300000; // 513 * 100000
  // ceil(2^32 / 3125), exact for dividends below 2^21
  localparam logic [20:0] RECIP_3125 = 21'd1374390;
  localparam logic signed [16:0] DB_HI = 17'(DEAD_BAND);
  localparam logic signed [16:0] DB_LO = -17'(DEAD_BAND);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DECIDE,
    ST_SUM,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } state_t;

  state_t state;

  logic [15:0] left_min, front_min, right_min;
  logic [15:0] cone_l_min, cone_r_min, cone_c_min;
  logic signed [10:0] prev_rate;

  logic signed [NUM_W-1:0] prod_d, prod_p;
  logic              num_neg;
  logic              num_clamp;
  logic [REM_W-1:0]  rem;
  logic [9:0]        quo;
  logic [15:0]       closest;

  logic signed [16:0]      diff;
  logic signed [16:0]      diff_db;
  logic signed [NUM_W-1:0] num_sum;
  logic [NUM_W-1:0]        num_abs;
  logic [41:0]             quo_prod;
  logic [10:0]             mag;
  logic signed [10:0]      rate_fin;
  logic [15:0]             closest_now;

  function automatic logic [15:0] fold(input logic hit, input logic first,
                                       input logic [15:0] cur,
                                       input logic [15:0] rmax,
                                       input logic [15:0] v);
    logic [15:0] base;
    base = first ? rmax : cur;
    return (hit && v < base) ? v : base;
  endfunction

  assign q_pop    = (state == ST_RUN) && !q_empty;
  assign res_push = (state == ST_EMIT) && res_ready;

  always_comb begin
    closest_now = (cone_l_min < cone_r_min) ? cone_l_min : cone_r_min;
    diff        = $signed({1'b0, cone_r_min}) - $signed({1'b0, cone_l_min});
    diff_db     = (diff > DB_LO && diff < DB_HI) ? '0 : diff;
    num_sum     = prod_d + prod_p;
    num_abs     = (num_sum < 0) ? NUM_W'(-num_sum) : NUM_W'(num_sum);
    // Unclamped magnitudes stay below 2^26, so rem/32 fits 21 bits
    quo_prod    = 42'(rem[25:5]) * 42'(RECIP_3125);
    mag         = num_clamp ? RATE_LIMIT : {1'b0, quo};
    rate_fin    = num_neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      prev_rate <= '0;
    end else begin
      case (state)
        // Fold one sample into the minima
        ST_RUN: begin
          if (!q_empty) begin
            left_min   <= fold(op.sector == SEC_LEFT, op.first, left_min,
                               cfg.range_max_mm, op.range_mm);
            front_min  <= fold(op.sector == SEC_FRONT, op.first, front_min,
                               cfg.range_max_mm, op.range_mm);
            right_min  <= fold(op.sector == SEC_RIGHT, op.first, right_min,
                               cfg.range_max_mm, op.range_mm);
            cone_l_min <= fold(op.cone_left, op.first, cone_l_min,
                               cfg.range_max_mm, op.range_mm);
            cone_r_min <= fold(op.cone_right, op.first, cone_r_min,
                               cfg.range_max_mm, op.range_mm);
            cone_c_min <= fold(op.cone_center, op.first, cone_c_min,
                               cfg.range_max_mm, op.range_mm);
            if (op.last) begin
              state <= ST_DECIDE;
            end
          end
        end
        // Build the report and pick the drive branch
        ST_DECIDE: begin
          res.left_min_mm       <= left_min;
          res.front_min_mm      <= front_min;
          res.right_min_mm      <= right_min;
          res.obstacle_near     <= (left_min < cfg.obstacle_threshold_mm) ||
                                   (front_min < cfg.obstacle_threshold_mm) ||
                                   (right_min < cfg.obstacle_threshold_mm);
          res.drive_valid       <= cfg.approach_enable;
          res.linear_speed_mm_s <= SPEED_STOP;
          closest               <= closest_now;
          if (!cfg.approach_enable) begin
            res.angular_rate <= '0;
            res.cone_reached <= 1'b0;
            state            <= ST_EMIT;
          end else if (closest_now >= cfg.cone_detect_mm) begin
            res.angular_rate <= SEARCH_RATE;
            res.cone_reached <= 1'b0;
            prev_rate        <= SEARCH_RATE;
            state            <= ST_EMIT;
          end else if (cone_c_min <= REACHED_MM) begin
            res.angular_rate <= '0;
            res.cone_reached <= 1'b1;
            state            <= ST_EMIT;
          end else begin
            res.angular_rate <= '0;
            res.cone_reached <= 1'b0;
            prod_d <= NUM_W'(diff_db) * GAIN_DIFF;
            prod_p <= NUM_W'(prev_rate) * GAIN_PREV;
            state  <= ST_SUM;
          end
        end
        // Combine terms, split sign and magnitude
        ST_SUM: begin
          num_neg   <= num_sum < 0;
          num_clamp <= num_abs[REM_W-1:0] >= CLAMP_ABS;
          rem       <= num_abs[REM_W-1:0];
          state     <= ST_DIV;
        end
        // Divide by 100000: drop the factor 32, multiply by 1/3125
        ST_DIV: begin
          quo   <= quo_prod[41:32];
          state <= ST_FINISH;
        end
        // Apply sign and limit, pick speed
        ST_FINISH: begin
          res.angular_rate <= rate_fin;
          prev_rate        <= rate_fin;
          if (mag >= FAST_TURN) begin
            res.linear_speed_mm_s <= SPEED_TURN;
          end else if (closest < CLOSE_MM) begin
            res.linear_speed_mm_s <= SPEED_CLOSE;
          end else begin
            res.linear_speed_mm_s <= SPEED_CRUISE;
          end
          state <= ST_EMIT;
        end
        // Hand the result to the output register
        ST_EMIT: begin
          if (res_ready) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

// File: rtl/core/lidar_sector_cone_approach_unit.sv
// ----------------------------------------------------------------------------
// lidar_sector_cone_approach_unit - lidar sector minima and cone approach
// Streams range samples, tracks sector and cone-window minima over a scan and
// reports them with an obstacle flag and an optional drive command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive range_mm / last_of_scan with push; a beat is taken
//   when push is high and full is low. One result per scan, produced by the
//   beat marked last_of_scan; other beats give no result.
//   Result channel: while empty is low the result ports hold the oldest
//   result; pop with empty low takes it.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once;
//   write only between scans with no result pending.
//   Throughput: one sample per cycle while full is low. A last sample holds
//   the back end in decide and multiply, sum, reciprocal divide by 100000,
//   finish and emit steps when steering, in decide and emit otherwise; the
//   4-entry sample queue and the input register take up to five samples
//   meanwhile, beyond that full rises until the back end resumes.
//   Path: a taken last sample passes the input register, the queue, the run
//   step and the steps above into the output register; it takes longer
//   while earlier samples are queued or the output register is occupied.
//   Stall: a result not popped holds the back end in its emit step; samples
//   then back up into the queue and full is raised.
//   Reset (rst, synchronous): queue and output register empty, scan index 0,
//   turn-rate history 0, registers at their default values.
// ----------------------------------------------------------------------------
module lidar_sector_cone_approach_unit #(
  parameter int MAX_SCAN = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Sample channel
  input  logic        push,
  output logic        full,
  input  logic [15:0] range_mm,
  input  logic        last_of_scan,
  // Result channel
  output logic        empty,
  input  logic        pop,
  output logic [15:0] left_min_mm,
  output logic [15:0] front_min_mm,
  output logic [15:0] right_min_mm,
  output logic        obstacle_near,
  output logic        drive_valid,
  output logic [7:0]  linear_speed_mm_s,
  output logic signed [10:0] angular_rate,
  output logic        cone_reached,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [lscap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lscap_pkg::*;

  cfg_t    cfg;
  op_t     f_data;
  op_t     b_data;
  logic    f_push;
  logic    q_full;
  logic    q_empty;
  logic    b_pop;
  logic    res_ready;
  logic    res_push;
  result_t res;
  result_t out_res;
  logic    out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_length           <= RST_SCAN_LENGTH;
      cfg.window_start          <= RST_WINDOW_START;
      cfg.window_end            <= RST_WINDOW_END;
      cfg.center_half_width     <= RST_CENTER_HALF;
      cfg.range_max_mm          <= RST_RANGE_MAX;
      cfg.obstacle_threshold_mm <= RST_OBSTACLE_THR;
      cfg.cone_detect_mm        <= RST_CONE_DETECT;
      cfg.approach_enable       <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SCAN_LENGTH:  cfg.scan_length           <= cfg_data[12:0];
        REG_WINDOW_START: cfg.window_start          <= cfg_data[11:0];
        REG_WINDOW_END:   cfg.window_end            <= cfg_data[11:0];
        REG_CENTER_HALF:  cfg.center_half_width     <= cfg_data[11:0];
        REG_RANGE_MAX:    cfg.range_max_mm          <= cfg_data;
        REG_OBSTACLE_THR: cfg.obstacle_threshold_mm <= cfg_data;
        REG_CONE_DETECT:  cfg.cone_detect_mm        <= cfg_data;
        REG_APPROACH:     cfg.approach_enable       <= cfg_data[0];
        default:          cfg.approach_enable       <= cfg.approach_enable;
      endcase
    end
  end

  lscap_front #(
    .MAX_SCAN (MAX_SCAN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .range_mm     (range_mm),
    .last_of_scan (last_of_scan),
    .q_full       (q_full),
    .q_push       (f_push),
    .q_data       (f_data)
  );

  lscap_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (f_data),
    .q_full  (q_full),
    .rd_en   (b_pop),
    .rd_data (b_data),
    .q_empty (q_empty)
  );

  lscap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op        (b_data),
    .q_empty   (q_empty),
    .q_pop     (b_pop),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  // Output register: load on a new result, drop on pop
  assign res_ready = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty             = !out_valid;
  assign left_min_mm       = out_res.left_min_mm;
  assign front_min_mm      = out_res.front_min_mm;
  assign right_min_mm      = out_res.right_min_mm;
  assign obstacle_near     = out_res.obstacle_near;
  assign drive_valid       = out_res.drive_valid;
  assign linear_speed_mm_s = out_res.linear_speed_mm_s;
  assign angular_rate      = out_res.angular_rate;
  assign cone_reached      = out_res.cone_reached;

  // Without approach mode the drive fields stay zero
  a_no_drive: assert property (@(posedge clk) disable iff (rst)
    (!empty && !drive_valid) |->
      (linear_speed_mm_s == SPEED_STOP && angular_rate == '0 && !cone_reached))
    else $error("drive fields set outside approach mode");

  // Reaching the cone stops the robot
  a_reached_stop: assert property (@(posedge clk) disable iff (rst)
    (!empty && cone_reached) |->
      (linear_speed_mm_s == SPEED_STOP && angular_rate == '0))
    else $error("cone reached but still moving");

  // Turn rate stays inside its limit
  a_rate_limit: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (angular_rate <= 11'sd512 && angular_rate >= -11'sd512))
    else $error("angular rate beyond limit");

  // Speed takes only the commanded levels
  a_speed_set: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (linear_speed_mm_s == SPEED_STOP || linear_speed_mm_s == SPEED_TURN ||
                linear_speed_mm_s == SPEED_CLOSE || linear_speed_mm_s == SPEED_CRUISE))
    else $error("unexpected speed level");

endmodule

// File: tb/lidar_sector_cone_approach_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sector_cone_approach_unit_tb - self-checking bench for the sector unit
// Streams range samples through the queue-style input. Scan reports are
// checked against a scoreboard that mirrors the minima, the obstacle flag and
// the approach steering. Both sides idle and stall at random, and registers
// are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module lidar_sector_cone_approach_unit_tb;
  import lscap_pkg::*;

  localparam int SCAN_CAP      = 4096;
  localparam int SECTOR_FLOOR  = 50;
  localparam int REACH_MM      = 300;
  localparam int SEARCH_TURN   = 512;
  localparam int TURN_CLAMP    = 512;
  localparam int QUICK_TURN    = 154;
  localparam int NEAR_MM       = 800;
  localparam int BAND_MM       = 100;
  localparam int TURN_SPEED    = 100;
  localparam int NEAR_SPEED    = 120;
  localparam int CRUISE_SPEED  = 200;
  localparam int IDLE_PCT      = 35;
  localparam int DRAIN_CYCLES  = 64;
  localparam int PHASE_SAMPLES = 45;
  localparam int RANDOM_PHASES = 10;
  localparam int LONG_SCAN     = 120;
  localparam int MAX_REPORTED  = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors registers and scan state, holds pending scan reports
  // --------------------------------------------------------------------------
  class scan_scoreboard;
    logic [12:0] scan_len;
    logic [11:0] win_first, win_last, center_half;
    logic [15:0] range_ceiling, obstacle_mm, detect_mm;
    logic        approach_on;
    int          sample_idx;
    logic [15:0] left_min, front_min, right_min, cone_l, cone_r, cone_c;
    int          prev_turn;
    result_t     reports_q[$];
    int          errors;
    int          checked;

    function new();
      scan_len      = 13'd450;
      win_first     = 12'd0;
      win_last      = 12'd449;
      center_half   = 12'd12;
      range_ceiling = 16'd12000;
      obstacle_mm   = 16'd1000;
      detect_mm     = 16'd2000;
      approach_on   = 1'b0;
      sample_idx    = 0;
      prev_turn     = 0;
      errors        = 0;
      checked       = 0;
      reload();
    endfunction

    function void reload();
      left_min  = range_ceiling;
      front_min = range_ceiling;
      right_min = range_ceiling;
      cone_l    = range_ceiling;
      cone_r    = range_ceiling;
      cone_c    = range_ceiling;
    endfunction

    function logic [15:0] lower(logic [15:0] a, logic [15:0] b);
      return (a < b) ? a : b;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] v);
      case (idx)
        REG_SCAN_LENGTH:  scan_len      = v[12:0];
        REG_WINDOW_START: win_first     = v[11:0];
        REG_WINDOW_END:   win_last      = v[11:0];
        REG_CENTER_HALF:  center_half   = v[11:0];
        REG_RANGE_MAX:    range_ceiling = v;
        REG_OBSTACLE_THR: obstacle_mm   = v;
        REG_CONE_DETECT:  detect_mm     = v;
        REG_APPROACH:     approach_on   = v[0];
        default: ;
      endcase
    endfunction

    // Fold one accepted beat into the scan; queue a report on the last one
    function void note_sample(logic [15:0] r, logic last);
      int          len, third, idx, mid;
      longint      d, num;
      logic [15:0] closest;
      int          turn;
      result_t     rep;
      len = (int'(scan_len) < SCAN_CAP) ? int'(scan_len) : SCAN_CAP;
      idx = sample_idx;
      mid = int'(win_first) + (int'(win_last) - int'(win_first)) / 2;
      if (idx == 0) reload();
      if (idx < len) begin
        third = len / 3;
        if (r > SECTOR_FLOOR) begin
          if (idx < third) left_min = lower(left_min, r);
          else if (idx < 2 * third) front_min = lower(front_min, r);
          else right_min = lower(right_min, r);
        end
        if (approach_on && r != 16'd0) begin
          if (idx >= int'(win_first) && idx <= mid) cone_l = lower(cone_l, r);
          if (idx > mid && idx <= int'(win_last)) cone_r = lower(cone_r, r);
          if (idx >= mid - int'(center_half) && idx <= mid + int'(center_half))
            cone_c = lower(cone_c, r);
        end
      end
      if (sample_idx < SCAN_CAP) sample_idx++;
      if (!last) return;

      rep = '0;
      rep.left_min_mm   = left_min;
      rep.front_min_mm  = front_min;
      rep.right_min_mm  = right_min;
      rep.obstacle_near = (left_min < obstacle_mm) || (front_min < obstacle_mm) ||
                          (right_min < obstacle_mm);
      rep.drive_valid   = approach_on;
      if (approach_on) begin
        closest = lower(cone_l, cone_r);
        if (closest >= detect_mm) begin
          // nothing in range: spin in place to search
          rep.angular_rate = 11'(SEARCH_TURN);
          prev_turn = SEARCH_TURN;
        end else if (cone_c <= REACH_MM) begin
          // at the cone: stop, keep the turn history
          rep.cone_reached = 1'b1;
        end else begin
          // proportional steer with dead band, smoothing and clamp
          d = longint'(cone_r) - longint'(cone_l);
          if (d > -BAND_MM && d < BAND_MM) d = 0;
          num = (64'sd4608 * d + 64'sd70000 * longint'(prev_turn)) / 100000;
          if (num > TURN_CLAMP) num = TURN_CLAMP;
          if (num < -TURN_CLAMP) num = -TURN_CLAMP;
          turn = int'(num);
          prev_turn = turn;
          rep.angular_rate = turn[10:0];
          if (turn >= QUICK_TURN || turn <= -QUICK_TURN) rep.linear_speed_mm_s = 8'(TURN_SPEED);
          else if (closest < NEAR_MM) rep.linear_speed_mm_s = 8'(NEAR_SPEED);
          else rep.linear_speed_mm_s = 8'(CRUISE_SPEED);
        end
      end
      reports_q.push_back(rep);
      sample_idx = 0;
    endfunction

    function string show(result_t v);
      return $sformatf("L %0d F %0d R %0d obst %0b drv %0b spd %0d turn %0d reached %0b",
                       v.left_min_mm, v.front_min_mm, v.right_min_mm, v.obstacle_near,
                       v.drive_valid, v.linear_speed_mm_s, $signed(v.angular_rate),
                       v.cone_reached);
    endfunction

    // Compare one popped report with the oldest pending one
    function void check_report(result_t got);
      result_t want;
      string   diffs;
      checked++;
      if (reports_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTED)
          $display("ERROR: report %0d with none pending: %s", checked, show(got));
        return;
      end
      want  = reports_q.pop_front();
      diffs = "";
      if (got.left_min_mm !== want.left_min_mm) diffs = {diffs, " left_min_mm"};
      if (got.front_min_mm !== want.front_min_mm) diffs = {diffs, " front_min_mm"};
      if (got.right_min_mm !== want.right_min_mm) diffs = {diffs, " right_min_mm"};
      if (got.obstacle_near !== want.obstacle_near) diffs = {diffs, " obstacle_near"};
      if (got.drive_valid !== want.drive_valid) diffs = {diffs, " drive_valid"};
      if (got.linear_speed_mm_s !== want.linear_speed_mm_s) diffs = {diffs, " linear_speed"};
      if (got.angular_rate !== want.angular_rate) diffs = {diffs, " angular_rate"};
      if (got.cone_reached !== want.cone_reached) diffs = {diffs, " cone_reached"};
      if (diffs != "") begin
        errors++;
        if (errors <= MAX_REPORTED)
          $display("ERROR: report %0d differs in%s\n  expected %s\n  actual   %s",
                   checked, diffs, show(want), show(got));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [15:0]        range_mm = '0;
  logic               last_of_scan = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [15:0]        left_min_mm, front_min_mm, right_min_mm;
  logic               obstacle_near, drive_valid, cone_reached;
  logic [7:0]         linear_speed_mm_s;
  logic signed [10:0] angular_rate;
  logic               cfg_we = 1'b0;
  reg_index_t         cfg_index = REG_SCAN_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scan_scoreboard sb = new();
  logic [15:0]    setting [8];
  int             idle_pct = IDLE_PCT;
  int             n_samples = 0;
  int             n_scans = 0;
  int             n_settings = 0;

  lidar_sector_cone_approach_unit dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .range_mm          (range_mm),
    .last_of_scan      (last_of_scan),
    .empty             (empty),
    .pop               (pop),
    .left_min_mm       (left_min_mm),
    .front_min_mm      (front_min_mm),
    .right_min_mm      (right_min_mm),
    .obstacle_near     (obstacle_near),
    .drive_valid       (drive_valid),
    .linear_speed_mm_s (linear_speed_mm_s),
    .angular_rate      (angular_rate),
    .cone_reached      (cone_reached),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("lidar_sector_cone_approach_unit test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check each popped beat, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    result_t got;
    if (!rst && pop && !empty) begin
      got.left_min_mm       = left_min_mm;
      got.front_min_mm      = front_min_mm;
      got.right_min_mm      = right_min_mm;
      got.obstacle_near     = obstacle_near;
      got.drive_valid       = drive_valid;
      got.linear_speed_mm_s = linear_speed_mm_s;
      got.angular_rate      = angular_rate;
      got.cone_reached      = cone_reached;
      sb.check_report(got);
    end
    pop <= ($urandom_range(99) >= idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Hold one beat until taken, with an occasional gap before it
  task automatic send_sample(input logic [15:0] r, input logic l);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    push         <= 1'b1;
    range_mm     <= r;
    last_of_scan <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_sample(r, l);
    n_samples++;
    if (l) n_scans++;
  endtask

  task automatic send_values(input logic [15:0] vals[$], input bit ends_scan);
    foreach (vals[i]) send_sample(vals[i], ends_scan && (i == vals.size() - 1));
  endtask

  // Mostly values near the cone thresholds, some extremes and noise
  function automatic logic [15:0] pick_range();
    int c;
    c = $urandom_range(99);
    if (c < 5) return 16'd0;
    if (c < 10) return 16'($urandom_range(1, SECTOR_FLOOR));
    if (c < 13) return 16'($urandom_range(SECTOR_FLOOR, SECTOR_FLOOR + 1));
    if (c < 16) return 16'hFFFF;
    if (c < 22) return 16'($urandom);
    if (c < 40) return 16'($urandom_range(100, 320));
    return 16'($urandom_range(300, 3000));
  endfunction

  task automatic send_scan(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_range(), i == n - 1);
  endtask

  // Drop push and wait for every pending report plus the pipeline tail
  task automatic drain();
    push <= 1'b0;
    while (sb.reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers from the setting array
  task automatic write_setting();
    reg_index_t ri;
    ri = ri.first();
    repeat (ri.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= ri;
      cfg_data  <= setting[ri];
      @(posedge clk);
      sb.set_reg(ri, setting[ri]);
      ri = ri.next();
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_setting(input int ph);
    int lim;
    setting[REG_SCAN_LENGTH] = (ph == 1) ? 16'd3 : (ph == 5) ? 16'd4096
                                                             : 16'($urandom_range(3, 40));
    lim = (setting[REG_SCAN_LENGTH] > 64) ? 64 : int'(setting[REG_SCAN_LENGTH]);
    setting[REG_WINDOW_START] = 16'($urandom_range(0, lim + 1));
    setting[REG_WINDOW_END]   = 16'($urandom_range(0, lim + 1));
    if (ph == 2) begin
      setting[REG_WINDOW_START] = 16'd0;
      setting[REG_WINDOW_END]   = 16'd4095;
    end else if (ph == 7) begin
      setting[REG_WINDOW_START] = 16'd4095;
      setting[REG_WINDOW_END]   = 16'd0;
    end
    setting[REG_CENTER_HALF] = (ph == 6) ? 16'd4095 : (ph == 4) ? 16'd0
                                                                : 16'($urandom_range(0, 4));
    case ($urandom_range(2))
      0: setting[REG_RANGE_MAX] = 16'hFFFF;
      1: setting[REG_RANGE_MAX] = 16'd12000;
      default: setting[REG_RANGE_MAX] = 16'($urandom_range(1000, 65535));
    endcase
    if (ph == 8) setting[REG_RANGE_MAX] = 16'd0;
    setting[REG_OBSTACLE_THR] = (ph == 8) ? 16'hFFFF : (ph == 1) ? 16'd0
                                                                 : 16'($urandom_range(0, 3000));
    setting[REG_CONE_DETECT] = (ph == 9) ? 16'd0 : (ph == 2) ? 16'hFFFF
                                                             : 16'($urandom_range(500, 5000));
    setting[REG_APPROACH] = (ph == 3 || ph == 7) ? 16'd0 : 16'd1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int len, n, kind, sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: six-sample scan, window 0..5, single-sample centre
    setting[REG_SCAN_LENGTH]  = 16'd6;
    setting[REG_WINDOW_START] = 16'd0;
    setting[REG_WINDOW_END]   = 16'd5;
    setting[REG_CENTER_HALF]  = 16'd0;
    setting[REG_RANGE_MAX]    = 16'hFFFF;
    setting[REG_OBSTACLE_THR] = 16'd1000;
    setting[REG_CONE_DETECT]  = 16'd2000;
    setting[REG_APPROACH]     = 16'd1;
    write_setting();
    // no-return and sub-floor samples, centre close enough to stop
    send_values('{16'd0, 16'd50, 16'd51, 16'hFFFF, 16'd400, 16'd350}, 1'b1);
    // plain steer toward the nearer right half
    send_values('{16'd1500, 16'd1400, 16'd1300, 16'd900, 16'd800, 16'd1000}, 1'b1);
    // short scan with nothing in range: search
    send_values('{16'd5000, 16'd6000, 16'd7000}, 1'b1);
    // short scan, huge left-right gap drives the turn into the clamp
    send_values('{16'd100, 16'd200}, 1'b1);
    // overlong scan with a threshold change halfway
    send_values('{16'd3000, 16'd3000, 16'd3000, 16'd3000}, 1'b0);
    drain();
    setting[REG_OBSTACLE_THR] = 16'hFFFF;
    write_setting();
    send_values('{16'd3000, 16'd3000, 16'd60, 16'd60, 16'd60}, 1'b1);

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      random_setting(ph);
      write_setting();
      idle_pct <= (ph == 4) ? 0 : IDLE_PCT;
      len  = (int'(setting[REG_SCAN_LENGTH]) < SCAN_CAP) ? int'(setting[REG_SCAN_LENGTH])
                                                         : SCAN_CAP;
      if (len > 64) len = 64;
      sent = n_samples;
      while (n_samples - sent < PHASE_SAMPLES) begin
        kind = $urandom_range(99);
        if (kind < 70) n = len;
        else if (kind < 82) n = $urandom_range(1, len);
        else if (kind < 94) n = len + $urandom_range(1, 6);
        else n = $urandom_range(1, 3);
        send_scan(n);
      end
    end

    // One scan under the longest length setting
    drain();
    idle_pct <= IDLE_PCT;
    setting[REG_SCAN_LENGTH]  = 16'd8191;
    setting[REG_WINDOW_START] = 16'd0;
    setting[REG_WINDOW_END]   = 16'd4095;
    setting[REG_CENTER_HALF]  = 16'd12;
    setting[REG_RANGE_MAX]    = 16'hFFFF;
    setting[REG_OBSTACLE_THR] = 16'd1000;
    setting[REG_CONE_DETECT]  = 16'd2000;
    setting[REG_APPROACH]     = 16'd1;
    write_setting();
    send_scan(LONG_SCAN);

    drain();
    $display("Run covered %0d samples in %0d scans under %0d register settings",
             n_samples, n_scans, n_settings);
    $display("%0d scan reports checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.reports_q.size() == 0) begin
      $display("lidar_sector_cone_approach_unit test passed");
    end else begin
      $display("lidar_sector_cone_approach_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lscap_pkg.sv
rtl/core/lscap_queue.sv
rtl/core/lscap_front.sv
rtl/core/lscap_back.sv
rtl/core/lidar_sector_cone_approach_unit.sv
tb/lidar_sector_cone_approach_unit_tb.sv
